[rtl/core/aabb_pkg.sv]
// Shared types and constants for the box overlap resolver.
// Depends on nothing; imported by the core, its port checker and the testbench.
`default_nettype none

package aabb_pkg;

  // Table sizes
  localparam int STATIC_DEPTH = 64;
  localparam int ENTITY_DEPTH = 64;

  // Field widths
  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 15;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int HIT_INDEX_W = 6;
  localparam int CFG_IDX_W   = 2;

  // Derived sizes
  localparam int DEPTH_MAX = (STATIC_DEPTH > ENTITY_DEPTH) ? STATIC_DEPTH : ENTITY_DEPTH;
  localparam int LIM_W0    = $clog2(DEPTH_MAX + 1);
  localparam int LIM_W     = (LIM_W0 > COUNT_W) ? LIM_W0 : COUNT_W;
  localparam int S_AW      = (STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1;
  localparam int E_AW      = (ENTITY_DEPTH > 1) ? $clog2(ENTITY_DEPTH) : 1;

  // Overlap terms need two extra bits, the position sum one more
  localparam int OV_W  = COORD_W + 2;
  localparam int ACC_W = COORD_W + 3;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ENTITY_COUNT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_LOAD_STATIC = 2'd0,
    OP_LOAD_ENTITY = 2'd1,
    OP_RESOLVE     = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  localparam logic [1:0] HIT_NONE   = 2'd0;
  localparam logic [1:0] HIT_STATIC = 2'd1;
  localparam logic [1:0] HIT_ENTITY = 2'd2;

  typedef enum logic {
    TBL_STATIC = 1'b0,
    TBL_ENTITY = 1'b1
  } tbl_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    op_t                       opcode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic [SIZE_W-1:0]         box_w;
    logic [SIZE_W-1:0]         box_h;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic [1:0]                hit_kind;
    logic [HIT_INDEX_W-1:0]    hit_index;
  } out_rsp_t;

  // One table entry
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_t;

endpackage

`default_nettype wire

[rtl/core/aabb_overlap_resolver.sv]
// Box overlap resolver core: two box tables in synchronous RAM and a scan pipeline.
// Depends on aabb_pkg for request, response and table entry types.
//
// Usage:
//   A request is taken when start is high and busy is low. in_req carries the
//   opcode, a slot, a box and a position. Every request gives one response on
//   out_rsp, shown for one cycle with out_valid high; the receiver cannot stall.
//   Load requests write one table slot and answer with all zeros on the next
//   cycle; busy stays low, so a load can be taken every cycle.
//   Resolve walks the static table, one box per cycle from slot 0, through a
//   four-stage read / overlap / decide / accumulate pipeline up to the static
//   count, clamped to the table depth, and answers with the corrected position
//   once the pipeline has drained. Query walks the static table the same way and
//   stops at the first hit; without a static hit it walks the entity table next.
//   busy is high until the response appears, and the next request can be taken
//   in the response cycle.
//   Configuration goes through cfg_we / cfg_index / cfg_wdata while idle.
//   Reset clears both counts and the control state; table contents stay
//   undefined until loaded.
`default_nettype none

module aabb_overlap_resolver (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire aabb_pkg::in_req_t                 in_req,
  output      logic                              out_valid,
  output      aabb_pkg::out_rsp_t                out_rsp,
  input  wire logic                              cfg_we,
  input  wire logic [aabb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [aabb_pkg::COUNT_W-1:0]      cfg_wdata
);

  import aabb_pkg::*;

  // Box tables
  box_t st_mem [STATIC_DEPTH];
  box_t en_mem [ENTITY_DEPTH];
  box_t st_rdata_r;
  box_t en_rdata_r;
  logic st_we;
  logic en_we;

  // Control state
  state_t           state_r, state_nxt;
  tbl_t             tbl_r, tbl_nxt;
  logic [LIM_W-1:0] iss_r, iss_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic             found_r, found_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic             ov_v_r, ov_v_nxt;
  logic             dc_v_r, dc_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] static_count_r;
  logic [COUNT_W-1:0] entity_count_r;

  // Request and pipeline payload
  in_req_t                   req_r, req_nxt;
  logic signed [OV_W-1:0]    ar_r, ar_nxt;
  logic signed [OV_W-1:0]    ab_r, ab_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt;
  logic signed [COORD_W-1:0] py_r, py_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic [HIT_INDEX_W-1:0]    hidx_r, hidx_nxt;
  out_rsp_t                  out_rsp_r, out_rsp_nxt;
  logic [LIM_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [LIM_W-1:0]          ov_idx_r, ov_idx_nxt;
  logic [LIM_W-1:0]          dc_idx_r, dc_idx_nxt;
  logic signed [OV_W-1:0]    ol_r, or_r, ot_r, ob_r;
  logic signed [OV_W-1:0]    ol_nxt, or_nxt, ot_nxt, ob_nxt;
  logic                      dc_hit_r, dc_hit_nxt;
  logic signed [ACC_W-1:0]   dx_r, dy_r, dx_nxt, dy_nxt;

  logic             issue;
  logic             scan_done;
  logic [LIM_W-1:0] st_lim;
  logic [LIM_W-1:0] en_lim;
  logic             slot_in_st;
  logic             slot_in_en;
  box_t             in_box;
  box_t             bx;
  logic signed [OV_W-1:0] bx_x, bx_y, ax_e, ay_e;
  logic signed [OV_W-1:0] m1, m2, mn;

  // Add a correction to a position and clamp it to 16 bits
  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] p,
    input logic signed [ACC_W-1:0]   d
  );
    logic signed [ACC_W-1:0] s;
    s = ACC_W'(p) + d;
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[COORD_W-1:0];
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Clamp the counts to the table depths
  assign st_lim = (LIM_W'(static_count_r) > LIM_W'(STATIC_DEPTH)) ?
                  LIM_W'(STATIC_DEPTH) : LIM_W'(static_count_r);
  assign en_lim = (LIM_W'(entity_count_r) > LIM_W'(ENTITY_DEPTH)) ?
                  LIM_W'(ENTITY_DEPTH) : LIM_W'(entity_count_r);

  assign slot_in_st = (LIM_W'(in_req.slot) < LIM_W'(STATIC_DEPTH));
  assign slot_in_en = (LIM_W'(in_req.slot) < LIM_W'(ENTITY_DEPTH));

  assign in_box = '{x: in_req.box_x, y: in_req.box_y, w: in_req.box_w, h: in_req.box_h};

  // Static table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[S_AW'(in_req.slot)] <= in_box;
    end
    st_rdata_r <= st_mem[S_AW'(iss_r)];
  end

  // Entity table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (en_we) begin
      en_mem[E_AW'(in_req.slot)] <= in_box;
    end
    en_rdata_r <= en_mem[E_AW'(iss_r)];
  end

  // Overlap stage: four side overlaps of the request box against the table box
  always_comb begin
    bx     = (tbl_r == TBL_ENTITY) ? en_rdata_r : st_rdata_r;
    bx_x   = OV_W'(bx.x);
    bx_y   = OV_W'(bx.y);
    ax_e   = OV_W'(req_r.box_x);
    ay_e   = OV_W'(req_r.box_y);
    ol_nxt = ar_r - bx_x;
    or_nxt = bx_x + OV_W'(bx.w) - ax_e;
    ot_nxt = ab_r - bx_y;
    ob_nxt = bx_y + OV_W'(bx.h) - ay_e;
  end

  // Decide stage: open-interval hit and the push along the smallest overlap
  always_comb begin
    dc_hit_nxt = (ol_r > 0) && (or_r > 0) && (ot_r > 0) && (ob_r > 0);
    m1 = (or_r < ol_r) ? or_r : ol_r;
    m2 = (ob_r < ot_r) ? ob_r : ot_r;
    mn = (m2 < m1) ? m2 : m1;
    if (mn == ol_r) begin
      dx_nxt = -ACC_W'(ol_r);
    end else if (mn == or_r) begin
      dx_nxt = ACC_W'(or_r);
    end else begin
      dx_nxt = '0;
    end
    if (mn == ot_r) begin
      dy_nxt = -ACC_W'(ot_r);
    end else if (mn == ob_r) begin
      dy_nxt = ACC_W'(ob_r);
    end else begin
      dy_nxt = '0;
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    tbl_nxt       = tbl_r;
    iss_nxt       = iss_r;
    lim_nxt       = lim_r;
    found_nxt     = found_r;
    req_nxt       = req_r;
    ar_nxt        = ar_r;
    ab_nxt        = ab_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    kind_nxt      = kind_r;
    hidx_nxt      = hidx_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    st_we         = 1'b0;
    en_we         = 1'b0;
    issue         = 1'b0;
    scan_done     = 1'b0;
    rd_v_nxt      = 1'b0;
    ov_v_nxt      = 1'b0;
    dc_v_nxt      = 1'b0;
    rd_idx_nxt    = iss_r;
    ov_idx_nxt    = rd_idx_r;
    dc_idx_nxt    = ov_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          ar_nxt    = OV_W'(in_req.box_x) + OV_W'(in_req.box_w);
          ab_nxt    = OV_W'(in_req.box_y) + OV_W'(in_req.box_h);
          px_nxt    = in_req.pos_x;
          py_nxt    = in_req.pos_y;
          found_nxt = 1'b0;
          kind_nxt  = HIT_NONE;
          hidx_nxt  = '0;
          iss_nxt   = '0;
          tbl_nxt   = TBL_STATIC;
          lim_nxt   = st_lim;
          case (in_req.opcode)
            OP_LOAD_STATIC: begin
              st_we         = slot_in_st;
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '0;
            end
            OP_LOAD_ENTITY: begin
              en_we         = slot_in_en;
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '0;
            end
            default: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle until the count is reached or a query hits
        issue = !found_r && (iss_r < lim_r);
        if (issue) begin
          iss_nxt = iss_r + LIM_W'(1);
        end
        rd_v_nxt = issue;
        ov_v_nxt = rd_v_r && !found_r;
        dc_v_nxt = ov_v_r && !found_r;

        // Accumulate corrections, or record the first query hit
        if (dc_v_r && dc_hit_r && !found_r) begin
          if (req_r.opcode == OP_RESOLVE) begin
            px_nxt = sat_add(px_r, dx_r);
            py_nxt = sat_add(py_r, dy_r);
          end else begin
            found_nxt = 1'b1;
            if (tbl_r == TBL_ENTITY) begin
              kind_nxt = HIT_ENTITY;
              hidx_nxt = dc_idx_r[HIT_INDEX_W-1:0];
            end else begin
              kind_nxt = HIT_STATIC;
              hidx_nxt = '0;
            end
          end
        end

        scan_done = found_r || ((iss_r >= lim_r) && !rd_v_r && !ov_v_r && !dc_v_r);
        if (scan_done) begin
          rd_v_nxt = 1'b0;
          ov_v_nxt = 1'b0;
          dc_v_nxt = 1'b0;
          if ((req_r.opcode == OP_QUERY) && (tbl_r == TBL_STATIC) && !found_r) begin
            // No static hit: walk the entity table next
            tbl_nxt = TBL_ENTITY;
            iss_nxt = '0;
            lim_nxt = en_lim;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
            if (req_r.opcode == OP_RESOLVE) begin
              out_rsp_nxt.new_x = px_r;
              out_rsp_nxt.new_y = py_r;
            end
            out_rsp_nxt.hit_kind  = kind_r;
            out_rsp_nxt.hit_index = hidx_r;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      tbl_r          <= TBL_STATIC;
      iss_r          <= '0;
      lim_r          <= '0;
      found_r        <= 1'b0;
      rd_v_r         <= 1'b0;
      ov_v_r         <= 1'b0;
      dc_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      static_count_r <= '0;
      entity_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      tbl_r       <= tbl_nxt;
      iss_r       <= iss_nxt;
      lim_r       <= lim_nxt;
      found_r     <= found_nxt;
      rd_v_r      <= rd_v_nxt;
      ov_v_r      <= ov_v_nxt;
      dc_v_r      <= dc_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_STATIC_COUNT: static_count_r <= cfg_wdata;
          CFG_ENTITY_COUNT: entity_count_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ar_r      <= ar_nxt;
    ab_r      <= ab_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    kind_r    <= kind_nxt;
    hidx_r    <= hidx_nxt;
    out_rsp_r <= out_rsp_nxt;
    rd_idx_r  <= rd_idx_nxt;
    ov_idx_r  <= ov_idx_nxt;
    dc_idx_r  <= dc_idx_nxt;
    ol_r      <= ol_nxt;
    or_r      <= or_nxt;
    ot_r      <= ot_nxt;
    ob_r      <= ob_nxt;
    dc_hit_r  <= dc_hit_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/aabb_overlap_resolver_chk.sv]
// Port-level checker for the box overlap resolver, bound into every resolver instance.
// Depends on aabb_pkg for the request and response types and codes.
`default_nettype none

module aabb_overlap_resolver_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire aabb_pkg::in_req_t  in_req,
  input wire logic               out_valid,
  input wire aabb_pkg::out_rsp_t out_rsp
);

  import aabb_pkg::*;

  // Answer a load request on the next cycle with an all-zero response
  a_load_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy &&
    (in_req.opcode == OP_LOAD_STATIC || in_req.opcode == OP_LOAD_ENTITY)
    |=> out_valid && out_rsp == '0 && !busy)
    else $error("load request not answered with zeros");

  // Hold busy after a resolve or query request is taken
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.opcode == OP_RESOLVE || in_req.opcode == OP_QUERY)
    |=> busy && !out_valid)
    else $error("scan request did not raise busy");

  // Drop busy in the same cycle a scan response appears
  a_busy_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a response");

  // Report an index only for an entity hit, and no position with a hit
  a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.hit_kind != HIT_ENTITY |-> out_rsp.hit_index == '0)
    else $error("hit index set without entity hit");

  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.hit_kind != HIT_NONE
    |-> out_rsp.new_x == '0 && out_rsp.new_y == '0 &&
        (out_rsp.hit_kind == HIT_STATIC || out_rsp.hit_kind == HIT_ENTITY))
    else $error("query response carries a position");

endmodule

bind aabb_overlap_resolver aabb_overlap_resolver_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

`default_nettype wire

[dv/resolver_tb_pkg.sv]
// Scoreboard class for the box overlap resolver testbench: a box-table
// predictor plus the queue of responses it expects. Depends on aabb_pkg.
package resolver_tb_pkg;
  import aabb_pkg::*;

  class resolver_scoreboard;
    box_t               static_tbl[STATIC_DEPTH];
    box_t               entity_tbl[ENTITY_DEPTH];
    logic [COUNT_W-1:0] static_cnt;
    logic [COUNT_W-1:0] entity_cnt;
    out_rsp_t           expected_rsp[$];
    int                 errors;

    function new();
      static_cnt = '0;
      entity_cnt = '0;
      errors     = 0;
    endfunction

    // Mirror a count register write; spare indexes do nothing
    function void set_count(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
      if (idx == CFG_STATIC_COUNT) begin
        static_cnt = val;
      end else if (idx == CFG_ENTITY_COUNT) begin
        entity_cnt = val;
      end
    endfunction

    function int outstanding();
      return expected_rsp.size();
    endfunction

    // Counts above the table depth act as the depth
    function int clip_count(logic [COUNT_W-1:0] cnt, int depth);
      return (int'(cnt) > depth) ? depth : int'(cnt);
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Open-interval test: shared edges do not count
    function bit boxes_hit(box_t a, box_t b);
      return !(int'(a.y) + int'(a.h) <= int'(b.y) ||
               int'(a.x) >= int'(b.x) + int'(b.w) ||
               int'(a.y) >= int'(b.y) + int'(b.h) ||
               int'(a.x) + int'(a.w) <= int'(b.x));
    endfunction

    // Apply one request to the tables and work out its response
    function out_rsp_t predict_response(in_req_t r);
      out_rsp_t rsp;
      box_t     a;
      box_t     b;
      int       px, py, n, i, ol, orr, ot, ob, mn;
      rsp = '0;
      a.x = r.box_x;
      a.y = r.box_y;
      a.w = r.box_w;
      a.h = r.box_h;
      case (r.opcode)
        OP_LOAD_STATIC: begin
          if (int'(r.slot) < STATIC_DEPTH) static_tbl[r.slot] = a;
        end
        OP_LOAD_ENTITY: begin
          if (int'(r.slot) < ENTITY_DEPTH) entity_tbl[r.slot] = a;
        end
        OP_RESOLVE: begin
          px = int'(r.pos_x);
          py = int'(r.pos_y);
          n  = clip_count(static_cnt, STATIC_DEPTH);
          for (i = 0; i < n; i++) begin
            b = static_tbl[i];
            if (boxes_hit(a, b)) begin
              ol  = int'(a.x) + int'(a.w) - int'(b.x);
              orr = int'(b.x) + int'(b.w) - int'(a.x);
              ot  = int'(a.y) + int'(a.h) - int'(b.y);
              ob  = int'(b.y) + int'(b.h) - int'(a.y);
              mn  = ol;
              if (orr < mn) mn = orr;
              if (ot < mn) mn = ot;
              if (ob < mn) mn = ob;
              // an x side and a y side may tie, then both axes move
              if (mn == ol) px = clamp16(px - ol);
              else if (mn == orr) px = clamp16(px + orr);
              if (mn == ot) py = clamp16(py - ot);
              else if (mn == ob) py = clamp16(py + ob);
            end
          end
          rsp.new_x = px[COORD_W-1:0];
          rsp.new_y = py[COORD_W-1:0];
        end
        OP_QUERY: begin
          n = clip_count(static_cnt, STATIC_DEPTH);
          for (i = 0; i < n; i++) begin
            if (boxes_hit(a, static_tbl[i])) begin
              rsp.hit_kind = HIT_STATIC;
              break;
            end
          end
          if (rsp.hit_kind == HIT_NONE) begin
            n = clip_count(entity_cnt, ENTITY_DEPTH);
            for (i = 0; i < n; i++) begin
              if (boxes_hit(a, entity_tbl[i])) begin
                rsp.hit_kind  = HIT_ENTITY;
                rsp.hit_index = i[HIT_INDEX_W-1:0];
                break;
              end
            end
          end
        end
      endcase
      return rsp;
    endfunction

    function void note_request(in_req_t r);
      expected_rsp.push_back(predict_response(r));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got,
                                time stamp);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", stamp, name, want, got);
      end
    endfunction

    // Compare a response against the oldest expectation
    function void check_response(out_rsp_t got, time stamp);
      out_rsp_t want;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", stamp, got);
        return;
      end
      want = expected_rsp.pop_front();
      compare_field("new_x", want.new_x, got.new_x, stamp);
      compare_field("new_y", want.new_y, got.new_y, stamp);
      compare_field("hit_kind", want.hit_kind, got.hit_kind, stamp);
      compare_field("hit_index", want.hit_index, got.hit_index, stamp);
    endfunction
  endclass

endpackage

[dv/testbench.sv]
// Top-level testbench for aabb_overlap_resolver: directed and random requests
// with random sender gaps. Depends on aabb_pkg and resolver_tb_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;
  import resolver_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = STATIC_DEPTH + ENTITY_DEPTH + 16;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_req_t              in_req;
  logic                 out_valid;
  out_rsp_t             out_rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]   cfg_wdata;

  resolver_scoreboard sb;
  int                 cycles = 0;

  aabb_overlap_resolver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch register writes, accepted requests and responses
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_count(cfg_index, cfg_wdata);
      if (start && !busy) sb.note_request(in_req);
      if (out_valid) sb.check_response(out_rsp, $time);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present a request and hold it until the block takes it
  task automatic send_request(input in_req_t r);
    @(negedge clk);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop start and wait for every outstanding response
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_req_t mk_req(op_t op, int slot, int x, int y, int w, int h,
                                     int px, int py);
    in_req_t r;
    r.opcode = op;
    r.slot   = SLOT_W'(slot);
    r.box_x  = COORD_W'(x);
    r.box_y  = COORD_W'(y);
    r.box_w  = SIZE_W'(w);
    r.box_h  = SIZE_W'(h);
    r.pos_x  = COORD_W'(px);
    r.pos_y  = COORD_W'(py);
    return r;
  endfunction

  // Coordinates: mostly a small arena so boxes collide, sometimes anywhere
  function automatic int rand_coord(bit wild);
    if (!wild) return int'($urandom_range(0, 1200)) - 600;
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 1) ? 32767 : -32768;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_size(bit wild);
    if (!wild) return int'($urandom_range(0, 300));
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 1) ? 32767 : 0;
    return int'($urandom_range(0, 32767));
  endfunction

  // Positions: arena, anywhere, or close to either rail to hit saturation
  function automatic int rand_pos();
    int off;
    off = int'($urandom_range(0, 400));
    case ($urandom_range(0, 2))
      0:       return int'($urandom_range(0, 1200)) - 600;
      1:       return int'($urandom_range(0, 65535)) - 32768;
      default: return ($urandom_range(0, 1) == 1) ? 32767 - off : -32768 + off;
    endcase
  endfunction

  function automatic in_req_t random_request(op_t op);
    bit wild;
    wild = ($urandom_range(0, 7) == 0);
    return mk_req(op, int'($urandom_range(0, 63)), rand_coord(wild), rand_coord(wild),
                  rand_size(wild), rand_size(wild), rand_pos(), rand_pos());
  endfunction

  function automatic op_t pick_op();
    case ($urandom_range(0, 9))
      0, 1:          return OP_LOAD_STATIC;
      2:             return OP_LOAD_ENTITY;
      3, 4, 5, 6:    return OP_RESOLVE;
      default:       return OP_QUERY;
    endcase
  endfunction

  initial begin
    int                 ph;
    int                 i;
    bit                 idle_on;
    logic [COUNT_W-1:0] s_cnt;
    logic [COUNT_W-1:0] e_cnt;
    in_req_t            r;

    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Seed a few slots, including the extremes of the field ranges
    send_request(mk_req(OP_LOAD_STATIC, 0, 0, 0, 100, 100, 0, 0));
    send_request(mk_req(OP_LOAD_STATIC, 1, 200, 0, 50, 50, 0, 0));
    send_request(mk_req(OP_LOAD_STATIC, 2, -32768, -32768, 32767, 32767, 0, 0));
    send_request(mk_req(OP_LOAD_STATIC, 3, 32767, 32767, 0, 0, 0, 0));
    send_request(mk_req(OP_LOAD_STATIC, 63, 32767, -32768, 32767, 0, -1, -1));
    send_request(mk_req(OP_LOAD_ENTITY, 0, 1000, 1000, 10, 10, 0, 0));
    send_request(mk_req(OP_LOAD_ENTITY, 1, 2000, 2000, 20, 20, 0, 0));
    send_request(mk_req(OP_LOAD_ENTITY, 63, -1, -1, 32767, 32767, 32767, -32768));
    // Counts are still zero after reset: nothing is scanned
    send_request(mk_req(OP_RESOLVE, 0, 10, 10, 20, 20, 5, -5));
    send_request(mk_req(OP_QUERY, 0, 10, 10, 20, 20, 0, 0));

    wait_drained();
    write_reg(CFG_SPARE_A, 7'd127);
    write_reg(CFG_SPARE_B, 7'd5);
    write_reg(CFG_STATIC_COUNT, 7'd4);
    write_reg(CFG_ENTITY_COUNT, 7'd2);

    // Left push, right push, touching edges, corner tie, both rails, empty box, widest box
    send_request(mk_req(OP_RESOLVE, 0, -10, 40, 20, 20, 100, 100));
    send_request(mk_req(OP_RESOLVE, 0, 90, 40, 20, 20, 32760, 0));
    send_request(mk_req(OP_RESOLVE, 0, 100, 0, 10, 10, 7, 7));
    send_request(mk_req(OP_RESOLVE, 0, -5, -5, 10, 10, 0, 0));
    send_request(mk_req(OP_RESOLVE, 0, -10, 40, 20, 20, -32768, 0));
    send_request(mk_req(OP_RESOLVE, 0, 40, 90, 20, 20, 0, 32765));
    send_request(mk_req(OP_RESOLVE, 0, 50, 50, 0, 0, -3, 3));
    send_request(mk_req(OP_RESOLVE, 0, -32768, -32768, 32767, 32767, 32767, -32768));
    // Static hit, entity hits at both used slots, and a miss
    send_request(mk_req(OP_QUERY, 0, 10, 10, 5, 5, 0, 0));
    send_request(mk_req(OP_QUERY, 0, 2005, 2005, 1, 1, 0, 0));
    send_request(mk_req(OP_QUERY, 0, 995, 995, 10, 10, 0, 0));
    send_request(mk_req(OP_QUERY, 0, 5000, 5000, 1, 1, 0, 0));

    // Fill both tables so any count is safe to scan
    for (i = 0; i < STATIC_DEPTH + ENTITY_DEPTH; i++) begin
      r      = random_request((i < STATIC_DEPTH) ? OP_LOAD_STATIC : OP_LOAD_ENTITY);
      r.slot = SLOT_W'(i % STATIC_DEPTH);
      send_request(r);
      if ($urandom_range(0, 3) == 0) idle_gap(int'($urandom_range(1, 17)));
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin s_cnt = 7'd64;  e_cnt = 7'd64;  end
        1:       begin s_cnt = 7'd0;   e_cnt = 7'd64;  end
        2:       begin s_cnt = 7'd1;   e_cnt = 7'd0;   end
        3:       begin s_cnt = 7'd127; e_cnt = 7'd100; end
        4:       begin s_cnt = 7'd0;   e_cnt = 7'd127; end
        5:       begin s_cnt = 7'd65;  e_cnt = 7'd1;   end
        default: begin
          s_cnt = COUNT_W'($urandom_range(0, 127));
          e_cnt = COUNT_W'($urandom_range(0, 127));
        end
      endcase
      // No sender gaps in one middle phase and in the closing phase
      idle_on = (ph != 2) && (ph != PHASES - 1);

      wait_drained();
      write_reg(CFG_STATIC_COUNT, s_cnt);
      write_reg(CFG_ENTITY_COUNT, e_cnt);

      repeat (PHASE_ITEMS) begin
        send_request(random_request(pick_op()));
        if (idle_on) begin
          if ($urandom_range(0, 3) == 0) idle_gap(int'($urandom_range(1, 17)));
          else if ($urandom_range(0, 40) == 0) wait_drained();
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
